// ===== rtl/core/fen_string_validator_top_macros.svh =====
// ----------------------------------------------------------------------------
// FEN string validator assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FEN_STRING_VALIDATOR_TOP_MACROS_SVH
`define FEN_STRING_VALIDATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define FSV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fsv assertion failed");
// Next-cycle implication
`define FSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fsv assertion failed");
`else
`define FSV_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define FSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/fsv_pkg.sv =====
// ----------------------------------------------------------------------------
// FEN string validator package
// Shared types, error codes, part indices and character constants.
// ----------------------------------------------------------------------------
package fsv_pkg;

    typedef logic [7:0] t_byte;

    // Verdict codes
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_FIELD_COUNT = 3'd1,
        ERR_BOARD       = 3'd2,
        ERR_SIDE        = 3'd3,
        ERR_CASTLING    = 3'd4,
        ERR_EN_PASSANT  = 3'd5,
        ERR_HALFMOVE    = 3'd6,
        ERR_FULLMOVE    = 3'd7
    } t_err_code;

    // Part indices
    localparam logic [2:0] PART_BOARD    = 3'd0;
    localparam logic [2:0] PART_SIDE     = 3'd1;
    localparam logic [2:0] PART_CASTLING = 3'd2;
    localparam logic [2:0] PART_EP       = 3'd3;
    localparam logic [2:0] PART_HALFMOVE = 3'd4;
    localparam logic [2:0] PART_FULLMOVE = 3'd5;
    localparam logic [2:0] PART_MAX      = 3'd7;

    localparam logic [3:0] RANK_COUNT  = 4'd8;
    localparam logic [3:0] RANK_MAX    = 4'd15;
    localparam logic [4:0] SQ_PER_RANK = 5'd8;
    localparam logic [4:0] SQ_MAX      = 5'd31;
    localparam logic [1:0] LEN_MAX     = 2'd3;

    // Characters
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_SLASH = 8'h2F;
    localparam t_byte CH_DASH  = 8'h2D;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;
    localparam t_byte CH_THREE = 8'h33;
    localparam t_byte CH_SIX   = 8'h36;
    localparam t_byte CH_FILE_A = 8'h61;
    localparam t_byte CH_FILE_H = 8'h68;
    localparam t_byte CH_WHITE = 8'h77;
    localparam t_byte CH_BLACK = 8'h62;

    function automatic logic is_digit(input t_byte c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_piece(input t_byte c);
        return (c == "K") || (c == "Q") || (c == "R") || (c == "B") || (c == "N") ||
               (c == "P") || (c == "k") || (c == "q") || (c == "r") || (c == "b") ||
               (c == "n") || (c == "p");
    endfunction

    // One-hot castling right for K, Q, k, q; zero for anything else
    function automatic logic [3:0] castle_bit(input t_byte c);
        logic [3:0] b;
        b = 4'b0000;
        if (c == "K") b = 4'b0001;
        if (c == "Q") b = 4'b0010;
        if (c == "k") b = 4'b0100;
        if (c == "q") b = 4'b1000;
        return b;
    endfunction

    // Keep the earliest error
    function automatic t_err_code flag_err(input t_err_code cur, input t_err_code code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

endpackage

// ===== rtl/core/fsv_in_if.sv =====
// ----------------------------------------------------------------------------
// FEN string validator input channel
// Valid/ready channel carrying one string byte and its last flag.
// ----------------------------------------------------------------------------
interface fsv_in_if import fsv_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/core/fsv_out_if.sv =====
// ----------------------------------------------------------------------------
// FEN string validator result channel
// Valid/ready channel carrying one verdict per string.
// ----------------------------------------------------------------------------
interface fsv_out_if import fsv_pkg::*; ();
    logic      valid;
    logic      ready;
    logic      valid_res;
    t_err_code error_code;

    modport source (output valid, output valid_res, output error_code, input ready);
    modport sink   (input valid, input valid_res, input error_code, output ready);
endinterface

// ===== rtl/core/fen_string_validator_top.sv =====
// ----------------------------------------------------------------------------
// FEN string validator
// Streams a FEN string byte by byte and gives one verdict per string.
// ----------------------------------------------------------------------------
// One byte is taken every cycle while input ready is high. Each transaction
// updates a small set of counters and flags in a single register stage; the
// byte flagged last also loads the verdict register, so the verdict appears
// in the cycle after that byte is taken, and the next string may start in
// that same cycle. Input ready drops only while a verdict sits in the
// output register and the sink is not taking it. Code 1 (field count) wins
// over all others; otherwise the code names the earliest failing field.
`include "fen_string_validator_top_macros.svh"

module fen_string_validator_top import fsv_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    fsv_in_if.sink     i_in,
    fsv_out_if.source  o_out
);

    // Parse state
    logic [2:0] r_part, n_part;
    logic [3:0] r_rank, n_rank;
    logic [4:0] r_sq,   n_sq;
    logic [1:0] r_len,  n_len;
    logic [3:0] r_cast, n_cast;
    t_byte      r_first, n_first;
    logic       r_nz,   n_nz;
    t_err_code  r_err,  n_err;
    logic       r_pend, n_pend;

    // Result register
    logic       r_out_valid;
    logic       r_valid_res, n_valid_res;
    t_err_code  r_err_out,   n_err_out;

    logic       in_acc;
    logic       last_acc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign last_acc   = in_acc && i_in.last;

    assign o_out.valid      = r_out_valid;
    assign o_out.valid_res  = r_valid_res;
    assign o_out.error_code = r_err_out;

    // Per-byte update: take the byte, then close the part on a space or last
    always_comb begin
        t_byte      c;
        logic       is_sp;
        logic [3:0] t_rank;
        logic [4:0] t_sq;
        logic [1:0] t_len;
        logic [3:0] t_cast;
        t_byte      t_first;
        logic       t_nz;
        t_err_code  t_err;
        logic       t_pend;
        logic [3:0] bit4;
        logic [5:0] sum;
        logic [3:0] rank_eff;
        t_err_code  close_code;
        t_err_code  err_closed;
        t_err_code  code;

        c      = i_in.character;
        is_sp  = (c == CH_SPACE);

        t_rank  = r_rank;
        t_sq    = r_sq;
        t_len   = r_len;
        t_cast  = r_cast;
        t_first = r_first;
        t_nz    = r_nz;
        t_err   = r_err;
        t_pend  = r_pend;
        bit4    = castle_bit(c);
        sum     = 6'd0;

        // Byte checks for the current part
        unique case (r_part)
            PART_BOARD: begin
                if (c == CH_SLASH) begin
                    if (r_sq != SQ_PER_RANK) t_err = flag_err(t_err, ERR_BOARD);
                    if (r_rank != RANK_MAX) t_rank = r_rank + 4'd1;
                    t_sq   = 5'd0;
                    t_pend = 1'b1;
                end else begin
                    t_pend = 1'b0;
                    if (is_digit(c)) begin
                        sum = {1'b0, r_sq} + {2'b00, c[3:0]};
                    end else if (is_piece(c)) begin
                        sum = {1'b0, r_sq} + 6'd1;
                    end else begin
                        sum = {1'b0, r_sq};
                        t_err = flag_err(t_err, ERR_BOARD);
                    end
                    t_sq = sum[5] ? SQ_MAX : sum[4:0];
                end
            end
            PART_CASTLING: begin
                if (bit4 != 4'b0000) begin
                    if ((r_cast & bit4) != 4'b0000) t_err = flag_err(t_err, ERR_CASTLING);
                    else t_cast = r_cast | bit4;
                end else if (!(c == CH_DASH && r_len == 2'd0)) begin
                    t_err = flag_err(t_err, ERR_CASTLING);
                end
            end
            PART_EP: begin
                if (r_len == 2'd1 && (r_first < CH_FILE_A || r_first > CH_FILE_H ||
                                      (c != CH_THREE && c != CH_SIX)))
                    t_err = flag_err(t_err, ERR_EN_PASSANT);
            end
            PART_HALFMOVE: begin
                if (!is_digit(c)) t_err = flag_err(t_err, ERR_HALFMOVE);
            end
            PART_FULLMOVE: begin
                if (!is_digit(c)) t_err = flag_err(t_err, ERR_FULLMOVE);
                else if (c != CH_ZERO) t_nz = 1'b1;
            end
            default: begin
            end
        endcase
        if (r_len == 2'd0) t_first = c;
        if (r_len != LEN_MAX) t_len = r_len + 2'd1;

        // A space closes the part as it stands; any other byte is taken first
        if (is_sp) begin
            t_rank  = r_rank;
            t_sq    = r_sq;
            t_len   = r_len;
            t_cast  = r_cast;
            t_first = r_first;
            t_nz    = r_nz;
            t_err   = r_err;
            t_pend  = r_pend;
        end

        // Part close checks
        close_code = ERR_NONE;
        rank_eff   = t_rank;
        unique case (r_part)
            PART_BOARD: begin
                if (t_len != 2'd0 && !t_pend) begin
                    if (t_sq != SQ_PER_RANK) close_code = ERR_BOARD;
                    if (t_rank != RANK_MAX) rank_eff = t_rank + 4'd1;
                end
                if (rank_eff != RANK_COUNT) close_code = ERR_BOARD;
            end
            PART_SIDE: begin
                if (!(t_len == 2'd1 && (t_first == CH_WHITE || t_first == CH_BLACK)))
                    close_code = ERR_SIDE;
            end
            PART_CASTLING: begin
                if (t_len == 2'd0 || (t_first == CH_DASH && t_len > 2'd1))
                    close_code = ERR_CASTLING;
            end
            PART_EP: begin
                if ((t_len == 2'd1) ? (t_first != CH_DASH) : (t_len != 2'd2))
                    close_code = ERR_EN_PASSANT;
            end
            PART_HALFMOVE: begin
                if (t_len == 2'd0) close_code = ERR_HALFMOVE;
            end
            PART_FULLMOVE: begin
                if (t_len == 2'd0 || !t_nz) close_code = ERR_FULLMOVE;
            end
            default: begin
            end
        endcase
        err_closed = flag_err(t_err, close_code);
        code = (r_part != PART_FULLMOVE) ? ERR_FIELD_COUNT : err_closed;

        n_valid_res = (code == ERR_NONE);
        n_err_out   = code;

        // Next state
        n_part  = r_part;
        n_rank  = t_rank;
        n_sq    = t_sq;
        n_len   = t_len;
        n_cast  = t_cast;
        n_first = t_first;
        n_nz    = t_nz;
        n_err   = t_err;
        n_pend  = t_pend;
        if (i_in.last || is_sp) begin
            n_rank  = 4'd0;
            n_sq    = 5'd0;
            n_len   = 2'd0;
            n_cast  = 4'd0;
            n_first = '0;
            n_nz    = 1'b0;
            n_pend  = 1'b0;
            n_err   = err_closed;
            if (i_in.last) begin
                n_part = PART_BOARD;
                n_err  = ERR_NONE;
            end else if (r_part != PART_MAX) begin
                n_part = r_part + 3'd1;
            end
        end
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part  <= PART_BOARD;
            r_rank  <= 4'd0;
            r_sq    <= 5'd0;
            r_len   <= 2'd0;
            r_cast  <= 4'd0;
            r_first <= '0;
            r_nz    <= 1'b0;
            r_err   <= ERR_NONE;
            r_pend  <= 1'b0;
        end else if (in_acc) begin
            r_part  <= n_part;
            r_rank  <= n_rank;
            r_sq    <= n_sq;
            r_len   <= n_len;
            r_cast  <= n_cast;
            r_first <= n_first;
            r_nz    <= n_nz;
            r_err   <= n_err;
            r_pend  <= n_pend;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (last_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_acc) begin
            r_valid_res <= n_valid_res;
            r_err_out   <= n_err_out;
        end
    end

    // Checks
    `FSV_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, last_acc, r_out_valid)
    `FSV_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, last_acc,
        r_part == PART_BOARD && r_err == ERR_NONE && r_len == 2'd0)
    `FSV_ASSERT_NOW(a_verdict_matches_code, i_clk, i_rst_n, r_out_valid,
        r_valid_res == (r_err_out == ERR_NONE))
    `FSV_ASSERT_NEXT(a_part_holds_in_field, i_clk, i_rst_n,
        in_acc && !i_in.last && i_in.character != CH_SPACE, $stable(r_part))

endmodule
